>>> sv/life_grid_generation_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the life grid generation engine
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH
`define LIFE_GRID_GENERATION_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define LGGE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define LGGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LGGE_ASSERT(lbl, clk, rst, prop, msg)
`define LGGE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/lgge_pkg.sv
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and constants of the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

  // command codes
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // register reset values and field widths
  localparam logic [6:0] WIDTH_RESET  = 7'd40;
  localparam logic [6:0] HEIGHT_RESET = 7'd20;
  localparam int         DIM_W        = 7;
  localparam int         ROW_BITS_W   = 64;
  localparam int         ROW_IDX_W    = 6;
  localparam int         S_TDATA_W    = 16;
  localparam int         M_TDATA_W    = 72;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_STEP_UP,
    ST_STEP_MID,
    ST_STEP_ROW,
    ST_READ_ROW,
    ST_RESULT
  } state_t;

endpackage

>>> sv/lgge_ram.sv
// ----------------------------------------------------------------------------
// lgge_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, read returns old data on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/lgge_row_unit.sv
// ----------------------------------------------------------------------------
// lgge_row_unit
// Next generation of one grid row from the old rows above, at and below it,
// with horizontal wraparound at the configured width.
// ----------------------------------------------------------------------------
module lgge_row_unit #(
  parameter int COLS   = 64,
  parameter int COL_AW = 6
) (
  input  logic [COLS-1:0]   up,
  input  logic [COLS-1:0]   mid,
  input  logic [COLS-1:0]   dn,
  input  logic [COLS-1:0]   mask,
  input  logic [COL_AW-1:0] last_col,
  output logic [COLS-1:0]   next_row
);

  logic [COLS-1:0] up_m;
  logic [COLS-1:0] mid_m;
  logic [COLS-1:0] dn_m;
  logic [COLS-1:0] res;

  assign up_m  = up & mask;
  assign mid_m = mid & mask;
  assign dn_m  = dn & mask;

  // one lane per column
  for (genvar c = 0; c < COLS; c++) begin : g_lane
    localparam int CL = (c == 0) ? 0 : c - 1;
    localparam int CR = (c == COLS - 1) ? 0 : c + 1;
    logic [7:0] nb;
    logic [3:0] cnt;

    // left / right neighbors, wrapping at the last used column
    always_comb begin
      nb[0] = (c == 0) ? up_m[last_col] : up_m[CL];
      nb[1] = up_m[c];
      nb[2] = (COL_AW'(c) == last_col) ? up_m[0] : up_m[CR];
      nb[3] = (c == 0) ? mid_m[last_col] : mid_m[CL];
      nb[4] = (COL_AW'(c) == last_col) ? mid_m[0] : mid_m[CR];
      nb[5] = (c == 0) ? dn_m[last_col] : dn_m[CL];
      nb[6] = dn_m[c];
      nb[7] = (COL_AW'(c) == last_col) ? dn_m[0] : dn_m[CR];
    end

    assign cnt = 4'(nb[0]) + 4'(nb[1]) + 4'(nb[2]) + 4'(nb[3])
               + 4'(nb[4]) + 4'(nb[5]) + 4'(nb[6]) + 4'(nb[7]);

    assign res[c] = mask[c] & ((cnt == lgge_pkg::BIRTH_COUNT) ||
                               (mid_m[c] && (cnt == lgge_pkg::SURVIVE_COUNT)));
  end

  // cells beyond the width keep their value
  assign next_row = (mid & ~mask) | res;

endmodule

>>> sv/life_grid_generation_engine.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// Game of Life (B3/S23) on a toroidal grid of up to 64 x 64 cells.
// ----------------------------------------------------------------------------
// One request at a time: s_tready is high only while the sequencer is idle.
// The grid lives in a RAM of one 64-bit word per row with a registered read;
// a set reads its row and writes it back (no write when the cell lies outside
// the grid), a step sweeps the grid once, one row per cycle through a
// row-wide neighbor counting unit, and a readout delivers one row per cycle
// while m_tready stays high. Each RAM row has a valid flag cleared by reset,
// so the grid reads as dead at once after reset with no clearing pass. Width
// and height registers (APB, byte addresses 0 and 4) must only be written
// while no request is in progress.
// ----------------------------------------------------------------------------
`include "life_grid_generation_engine_assert.svh"

module life_grid_generation_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] command, [7:2] col, [13:8] row, [14] alive, [15] zero
  input  logic [15:0] s_tdata,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] status, [6:1] row_index, [70:7] row_bits, [71] zero
  output logic [71:0] m_tdata,
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [6:0] MAX_W = 7'(MAX_COLS);
  localparam logic [6:0] MAX_H = 7'(MAX_ROWS);

  // configuration registers
  logic [6:0] grid_width;
  logic [6:0] grid_height;
  logic       cfg_wr;

  // sequencer
  lgge_pkg::state_t state;
  lgge_pkg::state_t state_next;

  // request fields
  logic       accept;
  logic [1:0] in_cmd;
  logic [5:0] in_col;
  logic [5:0] in_row;
  logic       in_alive;
  logic       coord_ok;

  // geometry
  logic [6:0]          eff_w;
  logic [6:0]          eff_h;
  logic [6:0]          eff_w_m1_full;
  logic [6:0]          eff_h_m1_full;
  logic [COL_AW-1:0]   eff_w_m1;
  logic [ROW_AW-1:0]   eff_h_m1;
  logic [MAX_COLS-1:0] col_mask;

  // datapath registers
  logic [ROW_AW-1:0]   row_cnt;
  logic                last_row;
  logic [COL_AW-1:0]   set_col;
  logic [ROW_AW-1:0]   set_row;
  logic                set_alive;
  logic                status;
  logic [MAX_COLS-1:0] up_row;
  logic [MAX_COLS-1:0] mid_row;
  logic [MAX_COLS-1:0] row0;
  logic [MAX_COLS-1:0] dn_row;
  logic [MAX_COLS-1:0] step_row;
  logic [MAX_COLS-1:0] set_bit;

  // memory interface
  logic                wr_en;
  logic [ROW_AW-1:0]   wr_addr;
  logic [MAX_COLS-1:0] wr_data;
  logic [ROW_AW-1:0]   rd_addr;
  logic [MAX_COLS-1:0] ram_rd;
  logic [MAX_COLS-1:0] rd_row;
  logic                rd_valid;
  logic [MAX_ROWS-1:0] row_valid;

  // output control
  logic out_free;
  logic load_result;
  logic load_row;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= lgge_pkg::WIDTH_RESET;
      grid_height <= lgge_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        grid_height <= pwdata[6:0];
      end else begin
        grid_width <= pwdata[6:0];
      end
    end
  end

  assign prdata = paddr[2] ? {25'd0, grid_height} : {25'd0, grid_width};

  // clamp to 1..MAX
  always_comb begin
    if (grid_width == 7'd0) begin
      eff_w = 7'd1;
    end else if (grid_width > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = grid_width;
    end
    if (grid_height == 7'd0) begin
      eff_h = 7'd1;
    end else if (grid_height > MAX_H) begin
      eff_h = MAX_H;
    end else begin
      eff_h = grid_height;
    end
  end

  assign eff_w_m1_full = eff_w - 7'd1;
  assign eff_h_m1_full = eff_h - 7'd1;
  assign eff_w_m1      = eff_w_m1_full[COL_AW-1:0];
  assign eff_h_m1      = eff_h_m1_full[ROW_AW-1:0];

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (7'(c) < eff_w);
    end
  end

  // ---------------------------------------------------------------- request
  assign s_tready = (state == lgge_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_cmd   = s_tdata[1:0];
  assign in_col   = s_tdata[7:2];
  assign in_row   = s_tdata[13:8];
  assign in_alive = s_tdata[14];
  assign coord_ok = ({1'b0, in_col} < eff_w) && ({1'b0, in_row} < eff_h);

  assign out_free = !m_tvalid || m_tready;
  assign last_row = (row_cnt == eff_h_m1);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      lgge_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            lgge_pkg::CMD_SET:  state_next = coord_ok ? lgge_pkg::ST_SET_WR
                                                      : lgge_pkg::ST_RESULT;
            lgge_pkg::CMD_STEP: state_next = lgge_pkg::ST_STEP_UP;
            lgge_pkg::CMD_READ: state_next = lgge_pkg::ST_READ_ROW;
            default:            state_next = lgge_pkg::ST_IDLE;
          endcase
        end
      end
      lgge_pkg::ST_SET_WR:   state_next = lgge_pkg::ST_RESULT;
      lgge_pkg::ST_STEP_UP:  state_next = lgge_pkg::ST_STEP_MID;
      lgge_pkg::ST_STEP_MID: state_next = lgge_pkg::ST_STEP_ROW;
      lgge_pkg::ST_STEP_ROW: begin
        if (last_row) begin
          state_next = lgge_pkg::ST_RESULT;
        end
      end
      lgge_pkg::ST_READ_ROW: begin
        if (out_free && last_row) begin
          state_next = lgge_pkg::ST_IDLE;
        end
      end
      lgge_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = lgge_pkg::ST_IDLE;
        end
      end
      default: state_next = lgge_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lgge_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- outputs
  assign set_bit = MAX_COLS'(1) << set_col;

  always_comb begin
    rd_addr     = row_cnt;
    wr_en       = 1'b0;
    wr_addr     = row_cnt;
    wr_data     = step_row;
    load_result = 1'b0;
    load_row    = 1'b0;
    case (state)
      lgge_pkg::ST_IDLE: begin
        // prefetch the first row the request needs
        case (in_cmd)
          lgge_pkg::CMD_SET:  rd_addr = in_row[ROW_AW-1:0];
          lgge_pkg::CMD_STEP: rd_addr = eff_h_m1;
          default:            rd_addr = '0;
        endcase
      end
      lgge_pkg::ST_SET_WR: begin
        wr_en   = 1'b1;
        wr_addr = set_row;
        wr_data = set_alive ? (rd_row | set_bit) : (rd_row & ~set_bit);
      end
      lgge_pkg::ST_STEP_UP:  rd_addr = '0;
      lgge_pkg::ST_STEP_MID: rd_addr = ROW_AW'(1);
      lgge_pkg::ST_STEP_ROW: begin
        rd_addr = row_cnt + ROW_AW'(2);
        wr_en   = 1'b1;
      end
      lgge_pkg::ST_READ_ROW: begin
        load_row = out_free;
        rd_addr  = out_free ? row_cnt + ROW_AW'(1) : row_cnt;
      end
      lgge_pkg::ST_RESULT: load_result = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- grid store
  lgge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS),
    .AW    (ROW_AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // per-row valid flags, an unwritten row reads as dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= (int'(rd_addr) < MAX_ROWS) && row_valid[rd_addr];
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_row = rd_valid ? ram_rd : '0;

  // ---------------------------------------------------------------- step unit
  assign dn_row = last_row ? row0 : rd_row;

  lgge_row_unit #(
    .COLS   (MAX_COLS),
    .COL_AW (COL_AW)
  ) u_row_unit (
    .up       (up_row),
    .mid      (mid_row),
    .dn       (dn_row),
    .mask     (col_mask),
    .last_col (eff_w_m1),
    .next_row (step_row)
  );

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      row_cnt   <= '0;
      set_col   <= in_col[COL_AW-1:0];
      set_row   <= in_row[ROW_AW-1:0];
      set_alive <= in_alive;
      status    <= (in_cmd == lgge_pkg::CMD_SET) && !coord_ok;
    end
    case (state)
      lgge_pkg::ST_STEP_UP: up_row <= rd_row;
      lgge_pkg::ST_STEP_MID: begin
        mid_row <= rd_row;
        row0    <= rd_row;
      end
      lgge_pkg::ST_STEP_ROW: begin
        // slide the old-generation window down one row
        up_row  <= mid_row;
        mid_row <= dn_row;
        row_cnt <= row_cnt + ROW_AW'(1);
      end
      lgge_pkg::ST_READ_ROW: begin
        if (out_free) begin
          row_cnt <= row_cnt + ROW_AW'(1);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_result || load_row) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      m_tdata <= {1'b0, {lgge_pkg::ROW_BITS_W{1'b0}}, {lgge_pkg::ROW_IDX_W{1'b0}}, status};
      m_tlast <= 1'b1;
    end else if (load_row) begin
      m_tdata <= {1'b0, lgge_pkg::ROW_BITS_W'(rd_row & col_mask),
                  lgge_pkg::ROW_IDX_W'(row_cnt), 1'b0};
      m_tlast <= last_row;
    end
  end

  // ---------------------------------------------------------------- assertions
  `LGGE_ASSERT(a_wr_in_grid, clk, rst, wr_en |-> (wr_addr <= eff_h_m1), "grid write beyond height")
  `LGGE_ASSERT(a_wr_marks_valid, clk, rst, wr_en |=> row_valid[$past(wr_addr)], "row not marked valid")
  `LGGE_ASSERT(a_err_result, clk, rst, (m_tvalid && m_tdata[0]) |-> (m_tlast && (m_tdata[70:7] == '0)), "bad error result")
  `LGGE_ASSERT_ALWAYS(a_reset_out, clk, $past(rst) |-> !m_tvalid, "result valid after reset")

endmodule

>>> verif/tb_life_grid_generation_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_life_grid_generation_engine
// Self-checking bench for the toroidal B3/S23 life grid engine. Requests are
// sent on the slave stream with random gaps. Each accepted request runs
// through a shadow copy of the grid that predicts the result rows. The master
// stream is stalled at random and once held off for a long stretch. Width and
// height are changed over APB between phases, covering tiny, clamped and
// full-size grids and cells that are hidden by a smaller grid.
// ----------------------------------------------------------------------------
module tb_life_grid_generation_engine;

  localparam int         GRID_MAX        = 64;
  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam logic [2:0] REG_WIDTH_ADDR  = 3'd0;
  localparam logic [2:0] REG_HEIGHT_ADDR = 3'd4;
  localparam int         DRAIN_CYCLES    = 80;
  localparam int         HOLD_CYCLES     = 400;
  localparam int         CYCLE_LIMIT     = 1_000_000;
  localparam int         IDLE_PERCENT    = 16;
  localparam int         MAX_REPORTS     = 10;

  typedef struct packed {
    logic        status;
    logic [5:0]  row_index;
    logic [63:0] row_bits;
    logic        last;
  } grid_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [1:0] command, [7:2] col, [13:8] row, [14] alive, [15] zero
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] status, [6:1] row_index, [70:7] row_bits, [71] zero
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow grid and register copies
  logic [63:0]  shadow_rows [GRID_MAX];
  logic [6:0]   cfg_width = lgge_pkg::WIDTH_RESET;
  logic [6:0]   cfg_height = lgge_pkg::HEIGHT_RESET;
  grid_result_t pending_results [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;
  bit          hold_toggle = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  grid_result_t want;

  life_grid_generation_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (got_val !== exp_val)
      note_mismatch($sformatf("%s expected %h got %h", name, exp_val, got_val));
  endtask

  // register value 0 acts as 1, anything above the maximum as the maximum
  function automatic int unsigned effective_dim(input logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  function automatic logic [63:0] column_mask(input int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic void queue_result(input logic status, input logic [5:0] idx,
                                       input logic [63:0] bits, input logic last);
    grid_result_t res;
    res.status    = status;
    res.row_index = idx;
    res.row_bits  = bits;
    res.last      = last;
    pending_results.push_back(res);
  endfunction

  // one generation on the torus; cells beyond the grid are kept as they are
  function automatic void advance_generation();
    logic [63:0] next_rows [GRID_MAX];
    logic [63:0] m;
    logic [63:0] born;
    int unsigned w, h, cnt, rr, cc;
    w = effective_dim(cfg_width);
    h = effective_dim(cfg_height);
    m = column_mask(w);
    for (int unsigned r = 0; r < h; r++) begin
      born = '0;
      for (int unsigned c = 0; c < w; c++) begin
        cnt = 0;
        // tiny grids: the same cell may fill several neighbor positions
        for (int unsigned dr = 0; dr < 3; dr++)
          for (int unsigned dc = 0; dc < 3; dc++)
            if (dr != 1 || dc != 1) begin
              rr = (r + h - 1 + dr) % h;
              cc = (c + w - 1 + dc) % w;
              cnt += 32'(shadow_rows[rr][cc]);
            end
        if (cnt == lgge_pkg::BIRTH_COUNT ||
            (shadow_rows[r][c] && cnt == lgge_pkg::SURVIVE_COUNT))
          born[c] = 1'b1;
      end
      next_rows[r] = (shadow_rows[r] & ~m) | born;
    end
    for (int unsigned r = 0; r < h; r++) shadow_rows[r] = next_rows[r];
  endfunction

  // expected result rows of one accepted request
  function automatic void predict_request(input logic [1:0] cmd, input logic [5:0] col,
                                          input logic [5:0] row, input logic alive);
    int unsigned w, h;
    logic [63:0] m;
    w = effective_dim(cfg_width);
    h = effective_dim(cfg_height);
    m = column_mask(w);
    case (cmd)
      lgge_pkg::CMD_SET: begin
        if (col >= w || row >= h) begin
          queue_result(1'b1, 6'd0, 64'd0, 1'b1);
        end else begin
          shadow_rows[row][col] = alive;
          queue_result(1'b0, 6'd0, 64'd0, 1'b1);
        end
      end
      lgge_pkg::CMD_STEP: begin
        advance_generation();
        queue_result(1'b0, 6'd0, 64'd0, 1'b1);
      end
      lgge_pkg::CMD_READ: begin
        for (int unsigned r = 0; r < h; r++)
          queue_result(1'b0, r[5:0], shadow_rows[r] & m, r == h - 1);
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result %h last %b", m_tdata, m_tlast));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(m_tdata[0]));
        check_field("row_index", 64'(want.row_index), 64'(m_tdata[6:1]));
        check_field("row_bits", want.row_bits, m_tdata[70:7]);
        check_field("last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  // result receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic [5:0] col,
                              input logic [5:0] row, input logic alive);
    if (!steady)
      while ($urandom_range(99, 0) < IDLE_PERCENT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, alive, row, col, cmd};
    do @(posedge clk); while (!s_tready);
    predict_request(cmd, col, row, alive);
  endtask

  // stop offering requests and let the block run dry
  task automatic quiesce_requests();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ($urandom() & 32'hFFFF_FF80) | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_WIDTH_ADDR) cfg_width = value;
    else cfg_height = value;
  endtask

  task automatic check_register(input logic [2:0] addr, input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field($sformatf("register @%0d", addr), 64'(value), 64'(prdata[6:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_grid_size(input logic [6:0] w, input logic [6:0] h);
    quiesce_requests();
    write_register(REG_WIDTH_ADDR, w);
    write_register(REG_HEIGHT_ADDR, h);
    check_register(REG_WIDTH_ADDR, w);
    check_register(REG_HEIGHT_ADDR, h);
  endtask

  // register defaults and a cleared grid after reset
  task automatic test_reset_state();
    check_register(REG_WIDTH_ADDR, lgge_pkg::WIDTH_RESET);
    check_register(REG_HEIGHT_ADDR, lgge_pkg::HEIGHT_RESET);
    send_request(lgge_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
  endtask

  // corner cells, out-of-grid sets, the unused command, clearing a cell
  task automatic test_set_bounds();
    send_request(lgge_pkg::CMD_SET, 6'd0, 6'd0, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd39, 6'd19, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd40, 6'd0, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd0, 6'd20, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd63, 6'd63, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd39, 6'd0, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd0, 6'd19, 1'b1);
    send_request(CMD_UNUSED, 6'd63, 6'd63, 1'b1);
    send_request(lgge_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
    send_request(lgge_pkg::CMD_SET, 6'd39, 6'd19, 1'b0);
    send_request(lgge_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_request(lgge_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
  endtask

  // a glider next to the wrap edges of an 8 x 8 torus
  task automatic test_glider();
    set_grid_size(7'd8, 7'd8);
    send_request(lgge_pkg::CMD_SET, 6'd1, 6'd0, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd2, 6'd1, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd0, 6'd2, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd1, 6'd2, 1'b1);
    send_request(lgge_pkg::CMD_SET, 6'd2, 6'd2, 1'b1);
    repeat (4) send_request(lgge_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_request(lgge_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
  endtask

  // mostly seeding, stepping and reading; some noise and out-of-grid sets
  task automatic run_generation_phase(input logic [6:0] w, input logic [6:0] h,
                                      input int unsigned count);
    int unsigned done, sel, wv, hv, base_c, base_r;
    logic [5:0] col, row;
    set_grid_size(w, h);
    wv     = effective_dim(cfg_width);
    hv     = effective_dim(cfg_height);
    base_c = $urandom_range(63, 0);
    base_r = $urandom_range(63, 0);
    done   = 0;
    while (done < count) begin
      sel = $urandom_range(99, 0);
      if (sel >= 93) begin
        send_request(CMD_UNUSED, 6'($urandom()), 6'($urandom()), 1'($urandom()));
      end else begin
        if (sel < 50) begin
          if ($urandom_range(1, 0) == 1) begin
            col = 6'((base_c + $urandom_range(3, 0)) % wv);
            row = 6'((base_r + $urandom_range(3, 0)) % hv);
          end else begin
            col = 6'($urandom_range(wv - 1, 0));
            row = 6'($urandom_range(hv - 1, 0));
          end
          send_request(lgge_pkg::CMD_SET, col, row, $urandom_range(99, 0) < 80);
        end else if (sel < 58) begin
          send_request(lgge_pkg::CMD_SET, 6'($urandom()), 6'($urandom()),
                       1'($urandom()));
        end else if (sel < 78) begin
          send_request(lgge_pkg::CMD_STEP, 6'($urandom()), 6'($urandom()),
                       1'($urandom()));
        end else begin
          send_request(lgge_pkg::CMD_READ, 6'($urandom()), 6'($urandom()),
                       1'($urandom()));
        end
        done++;
      end
    end
    send_request(lgge_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
  endtask

  task automatic test_random_generations();
    run_generation_phase(7'd64, 7'd64, 40);
    run_generation_phase(7'd1, 7'd1, 25);
    run_generation_phase(7'd2, 7'd2, 30);
    run_generation_phase(7'd1, 7'd6, 25);
    run_generation_phase(7'd7, 7'd1, 25);
    run_generation_phase(7'd2, 7'd3, 25);
    run_generation_phase(7'd0, 7'd0, 15);
    // back to full size: cells left from the first phase show up again
    run_generation_phase(7'd127, 7'd127, 15);
    run_generation_phase(7'd100, 7'd5, 30);
    run_generation_phase(7'd3, 7'd65, 30);
    repeat (3)
      run_generation_phase(7'($urandom_range(16, 1)), 7'($urandom_range(16, 1)), 35);
  endtask

  // no idling on either side
  task automatic test_steady_stream();
    steady = 1'b1;
    run_generation_phase(7'd16, 7'd16, 40);
    quiesce_requests();
    steady = 1'b0;
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_output_hold();
    set_grid_size(7'd64, 7'd32);
    repeat (6)
      send_request(lgge_pkg::CMD_SET, 6'($urandom()), 6'($urandom_range(31, 0)), 1'b1);
    hold_toggle = ~hold_toggle;
    send_request(lgge_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
    send_request(lgge_pkg::CMD_SET, 6'($urandom()), 6'($urandom_range(31, 0)), 1'b1);
    send_request(lgge_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0);
    send_request(lgge_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
    send_request(lgge_pkg::CMD_SET, 6'($urandom()), 6'($urandom()), 1'b1);
    send_request(lgge_pkg::CMD_READ, 6'd0, 6'd0, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < GRID_MAX; i++) shadow_rows[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_set_bounds();
    test_glider();
    test_random_generations();
    test_steady_stream();
    test_output_hold();
    quiesce_requests();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/lgge_pkg.sv
sv/lgge_ram.sv
sv/lgge_row_unit.sv
sv/life_grid_generation_engine.sv
verif/tb_life_grid_generation_engine.sv
